[hw/rtl/aescbc_pkg.sv]
// Shared types, S-box tables and GF(2^8) helpers for the AES-128 CBC decrypt block.
// No dependencies; every other file in hw/rtl depends on this package.
package aescbc_pkg;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;
    typedef logic [31:0]  word_t;

    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 8'd0,
        REG_KEY_LOW  = 8'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic start;
    } key_ctrl_t;

    typedef struct packed {
        logic busy;
    } key_stat_t;

    typedef struct packed {
        logic en;
        logic first;
        logic last;
    } round_ctrl_t;

    localparam byte_t RCON_INIT = 8'h01;
    localparam byte_t GF_POLY   = 8'h1b;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t SBOX_DEC [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // Byte 0 sits in bits 127:120.
    function automatic byte_t get_byte(input block_t s, input int idx);
        return s[127 - 8 * idx -: 8];
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Next round key from the current one, standard AES-128 schedule.
    function automatic block_t key_next(input block_t rk, input byte_t rcon);
        word_t t;
        word_t n0;
        word_t n1;
        word_t n2;
        word_t n3;
        t  = sub_word({rk[23:0], rk[31:24]}) ^ {rcon, 24'h000000};
        n0 = rk[127:96] ^ t;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = rk[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // Inverse ShiftRows then inverse SubBytes; byte index is col*4+row.
    function automatic block_t inv_shift_sub(input block_t s);
        block_t r;
        r = '0;
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                r[127 - 8 * (col * 4 + row) -: 8] =
                    SBOX_DEC[get_byte(s, ((col - row + 4) % 4) * 4 + row)];
            end
        end
        return r;
    endfunction

    function automatic block_t inv_mix(input block_t s);
        block_t r;
        byte_t  a [4];
        byte_t  m2 [4];
        byte_t  m4 [4];
        byte_t  m8 [4];
        byte_t  x9 [4];
        byte_t  xb [4];
        byte_t  xd [4];
        byte_t  xe [4];
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                a[i]  = get_byte(s, c * 4 + i);
                m2[i] = xtime(a[i]);
                m4[i] = xtime(m2[i]);
                m8[i] = xtime(m4[i]);
                x9[i] = m8[i] ^ a[i];
                xb[i] = m8[i] ^ m2[i] ^ a[i];
                xd[i] = m8[i] ^ m4[i] ^ a[i];
                xe[i] = m8[i] ^ m4[i] ^ m2[i];
            end
            r[127 - 8 * (c * 4)     -: 8] = xe[0] ^ xb[1] ^ xd[2] ^ x9[3];
            r[127 - 8 * (c * 4 + 1) -: 8] = x9[0] ^ xe[1] ^ xb[2] ^ xd[3];
            r[127 - 8 * (c * 4 + 2) -: 8] = xd[0] ^ x9[1] ^ xe[2] ^ xb[3];
            r[127 - 8 * (c * 4 + 3) -: 8] = xb[0] ^ xd[1] ^ x9[2] ^ xe[3];
        end
        return r;
    endfunction

endpackage

[hw/rtl/aescbc_intf.sv]
// Valid/ready channel interfaces: ciphertext in, plaintext out, key register writes.
// Depends on aescbc_pkg for the register index width.
interface aescbc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        chain_start;

    modport source (output valid, output cipher_high, output cipher_low,
                    output chain_start, input ready);
    modport sink   (input valid, input cipher_high, input cipher_low,
                    input chain_start, output ready);
endinterface

interface aescbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_high;
    logic [63:0] plain_low;

    modport source (output valid, output plain_high, output plain_low, input ready);
    modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

interface aescbc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aescbc_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/aescbc_key_expand.sv]
// Iterative key schedule: one round key per cycle into the round key store.
// Depends on aescbc_pkg (S-box, key_next, control structs).
module aescbc_key_expand #(
    parameter int ROUNDS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  aescbc_pkg::key_ctrl_t       ctrl,
    input  aescbc_pkg::block_t          key,
    input  logic [$clog2(ROUNDS+1)-1:0] rd_addr,
    output aescbc_pkg::block_t          rd_data,
    output aescbc_pkg::key_stat_t       stat
);
    import aescbc_pkg::*;

    localparam int AW = $clog2(ROUNDS + 1);

    block_t          rk_mem [ROUNDS+1];
    block_t          rd_data_reg;
    block_t          work_reg;
    block_t          work_next;
    byte_t           rcon_reg;
    byte_t           rcon_next;
    logic [AW-1:0]   cnt_reg;
    logic [AW-1:0]   cnt_next;
    logic            busy_reg;
    logic            busy_next;

    always_comb
    begin
        work_next = work_reg;
        rcon_next = rcon_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.start)
        begin
            work_next = key;
            rcon_next = RCON_INIT;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = key_next(work_reg, rcon_reg);
            rcon_next = xtime(rcon_reg);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == AW'(ROUNDS))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rcon_reg <= rcon_next;
    end

    // Store write while expanding, registered read for the round unit.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !ctrl.start)
        begin
            rk_mem[cnt_reg] <= work_reg;
        end
        rd_data_reg <= rk_mem[rd_addr];
    end

    assign rd_data   = rd_data_reg;
    assign stat.busy = busy_reg;

endmodule

[hw/rtl/aescbc_round.sv]
// Shared inverse round unit: holds the cipher state and applies one round per cycle.
// Depends on aescbc_pkg (inv_shift_sub, inv_mix, round_ctrl_t).
module aescbc_round (
    input  logic                    clk,
    input  aescbc_pkg::round_ctrl_t ctrl,
    input  aescbc_pkg::block_t      cipher,
    input  aescbc_pkg::block_t      round_key,
    output aescbc_pkg::block_t      state
);
    import aescbc_pkg::*;

    block_t state_reg;
    block_t state_next;
    block_t pre;
    block_t keyed;

    // First step is the plain key addition; the last skips the column mix.
    always_comb
    begin
        pre        = ctrl.first ? cipher : inv_shift_sub(state_reg);
        keyed      = pre ^ round_key;
        state_next = state_reg;
        if (ctrl.en)
        begin
            state_next = (ctrl.first || ctrl.last) ? keyed : inv_mix(keyed);
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

[hw/rtl/aes128_cbc_decrypt.sv]
// AES-128 CBC decrypt. A request goes from IDLE through LOAD and ROUND to FINISH, passing through
// EXPAND for key expansion on the first request after reset or after a key register write.
// Ciphertext is taken only in IDLE, so a new block waits until the last is loaded for output;
// the shared round unit runs 11 steps per block (initial key addition and ten inverse rounds)
// with one round key read per step. Reset clears control, the key registers and the chaining
// value; the round key store is rebuilt from the key registers before the first block.
module aes128_cbc_decrypt #(
    parameter int ROUNDS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    aescbc_in_if.sink           cipher,
    aescbc_out_if.source        plain,
    aescbc_cfg_if.sink          cfg
);
    import aescbc_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);

    seq_state_t      state_reg;
    seq_state_t      state_next;
    logic [RW-1:0]   round_cnt_reg;
    logic [RW-1:0]   round_cnt_next;
    logic [63:0]     key_high_reg;
    logic [63:0]     key_low_reg;
    logic            stale_reg;
    logic [63:0]     prev_high_reg;
    logic [63:0]     prev_low_reg;
    block_t          cipher_reg;
    logic            chain_reg;
    logic            out_valid_reg;
    block_t          plain_reg;

    logic            in_fire;
    logic            cfg_fire;
    logic            out_load;
    key_ctrl_t       key_ctrl;
    key_stat_t       key_stat;
    round_ctrl_t     rnd_ctrl;
    logic [RW-1:0]   rd_addr;
    block_t          round_key;
    block_t          rnd_state;
    block_t          chain_val;

    assign in_fire  = cipher.valid && cipher.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    aescbc_key_expand #(
        .ROUNDS (ROUNDS)
    ) u_key (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (key_ctrl),
        .key     ({key_high_reg, key_low_reg}),
        .rd_addr (rd_addr),
        .rd_data (round_key),
        .stat    (key_stat)
    );

    aescbc_round u_round (
        .clk       (clk),
        .ctrl      (rnd_ctrl),
        .cipher    (cipher_reg),
        .round_key (round_key),
        .state     (rnd_state)
    );

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        round_cnt_next = round_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = stale_reg ? ST_EXPAND : ST_LOAD;
                end
            end
            ST_EXPAND:
            begin
                if (!key_stat.busy)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                round_cnt_next = RW'(ROUNDS);
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_cnt_next = round_cnt_reg - 1'b1;
                if (round_cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || plain.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cipher.ready   = 1'b0;
        key_ctrl.start = 1'b0;
        rd_addr        = round_cnt_reg - 1'b1;
        rnd_ctrl.en    = 1'b0;
        rnd_ctrl.first = 1'b0;
        rnd_ctrl.last  = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cipher.ready   = 1'b1;
                key_ctrl.start = cipher.valid && stale_reg;
            end
            ST_EXPAND:
            begin
                rd_addr = RW'(ROUNDS);
            end
            ST_LOAD:
            begin
                // Prefetch the last round key for the initial addition.
                rd_addr = RW'(ROUNDS);
            end
            ST_ROUND:
            begin
                rnd_ctrl.en    = 1'b1;
                rnd_ctrl.first = (round_cnt_reg == RW'(ROUNDS));
                rnd_ctrl.last  = (round_cnt_reg == '0);
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || plain.ready;
            end
            default:
            begin
                cipher.ready = 1'b0;
            end
        endcase
    end

    assign chain_val = chain_reg ? '0 : {prev_high_reg, prev_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_cnt_reg <= '0;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            stale_reg     <= 1'b1;
            prev_high_reg <= '0;
            prev_low_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            if (cfg_fire && cfg.index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg.data;
                stale_reg    <= 1'b1;
            end
            else if (cfg_fire && cfg.index == REG_KEY_LOW)
            begin
                key_low_reg <= cfg.data;
                stale_reg   <= 1'b1;
            end
            else if (key_ctrl.start)
            begin
                stale_reg <= 1'b0;
            end
            if (out_load)
            begin
                prev_high_reg <= cipher_reg[127:64];
                prev_low_reg  <= cipher_reg[63:0];
                out_valid_reg <= 1'b1;
            end
            else if (plain.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cipher_reg <= {cipher.cipher_high, cipher.cipher_low};
            chain_reg  <= cipher.chain_start;
        end
        if (out_load)
        begin
            plain_reg <= rnd_state ^ chain_val;
        end
    end

    assign plain.valid      = out_valid_reg;
    assign plain.plain_high = plain_reg[127:64];
    assign plain.plain_low  = plain_reg[63:0];

    // Round key store must be settled before any round reads it.
    a_no_expand_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND || state_reg == ST_LOAD) |-> !key_stat.busy)
        else $error("key expansion active during decryption rounds");

    a_round_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_cnt_reg <= RW'(ROUNDS)))
        else $error("round counter out of range");

    a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("block finished without a result");

    a_expand_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        key_ctrl.start |=> (key_stat.busy && state_reg == ST_EXPAND))
        else $error("key expansion did not start");

endmodule

[test/cbc_check_pkg.sv]
`timescale 1ns / 100ps
// Plaintext tracker for the AES-128 CBC decrypt testbench: key schedule, inverse cipher,
// chaining and the queue of plaintext blocks still due. Depends on aescbc_pkg for indexes.
package cbc_check_pkg;

    import aescbc_pkg::CFG_IDX_W;
    import aescbc_pkg::REG_KEY_HIGH;
    import aescbc_pkg::REG_KEY_LOW;

    localparam int         ROUNDS      = 10;
    localparam logic [7:0] REDUCE_POLY = 8'h1b;
    localparam logic [7:0] AFFINE_C    = 8'h63;
    localparam logic [7:0] RCON_FIRST  = 8'h01;
    localparam logic [7:0] RCON_STEP   = 8'h02;
    localparam logic [7:0] MIX_E       = 8'h0e;
    localparam logic [7:0] MIX_B       = 8'h0b;
    localparam logic [7:0] MIX_D       = 8'h0d;
    localparam logic [7:0] MIX_9       = 8'h09;

    class cbc_plain_check;
        logic [7:0]   fwd_box [256];
        logic [7:0]   inv_box [256];
        logic [63:0]  key_high;
        logic [63:0]  key_low;
        logic [63:0]  chain_high;
        logic [63:0]  chain_low;
        logic [127:0] round_key [ROUNDS + 1];
        bit           keys_stale;
        logic [127:0] plain_due [$];
        int           errors;

        function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
            logic [7:0] p;
            p = '0;
            for (int i = 0; i < 8; i++) begin
                if (b[i])
                    p ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
            end
            return p;
        endfunction

        function new();
            logic [7:0] x;
            logic [7:0] recip;
            logic [7:0] s;
            // build the S-box from the field inverse and the affine map
            for (int v = 0; v < 256; v++) begin
                x = v[7:0];
                recip = '0;
                for (int y = 1; y < 256; y++)
                    if (gf_mul(x, y[7:0]) == 8'h01)
                        recip = y[7:0];
                s = recip ^ {recip[6:0], recip[7]} ^ {recip[5:0], recip[7:6]}
                    ^ {recip[4:0], recip[7:5]} ^ {recip[3:0], recip[7:4]} ^ AFFINE_C;
                fwd_box[x] = s;
                inv_box[s] = x;
            end
            key_high   = '0;
            key_low    = '0;
            chain_high = '0;
            chain_low  = '0;
            keys_stale = 1'b1;
            errors     = 0;
        endfunction

        function void write_key(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
            if (index == REG_KEY_HIGH) begin
                key_high   = value;
                keys_stale = 1'b1;
            end else if (index == REG_KEY_LOW) begin
                key_low    = value;
                keys_stale = 1'b1;
            end
        endfunction

        function logic [127:0] invert_block(logic [127:0] c);
            logic [7:0]   st [16];
            logic [7:0]   t [16];
            logic [127:0] packed_st;
            for (int i = 0; i < 16; i++)
                st[i] = c[127 - 8 * i -: 8] ^ round_key[ROUNDS][127 - 8 * i -: 8];
            for (int r = ROUNDS - 1; r >= 0; r--) begin
                t = st;
                for (int row = 0; row < 4; row++)
                    for (int col = 0; col < 4; col++)
                        st[col * 4 + row] = inv_box[t[((col - row + 4) % 4) * 4 + row]];
                for (int i = 0; i < 16; i++)
                    st[i] ^= round_key[r][127 - 8 * i -: 8];
                if (r != 0) begin
                    t = st;
                    for (int k = 0; k < 4; k++) begin
                        st[k * 4]     = gf_mul(t[k * 4], MIX_E) ^ gf_mul(t[k * 4 + 1], MIX_B)
                                      ^ gf_mul(t[k * 4 + 2], MIX_D) ^ gf_mul(t[k * 4 + 3], MIX_9);
                        st[k * 4 + 1] = gf_mul(t[k * 4], MIX_9) ^ gf_mul(t[k * 4 + 1], MIX_E)
                                      ^ gf_mul(t[k * 4 + 2], MIX_B) ^ gf_mul(t[k * 4 + 3], MIX_D);
                        st[k * 4 + 2] = gf_mul(t[k * 4], MIX_D) ^ gf_mul(t[k * 4 + 1], MIX_9)
                                      ^ gf_mul(t[k * 4 + 2], MIX_E) ^ gf_mul(t[k * 4 + 3], MIX_B);
                        st[k * 4 + 3] = gf_mul(t[k * 4], MIX_B) ^ gf_mul(t[k * 4 + 1], MIX_D)
                                      ^ gf_mul(t[k * 4 + 2], MIX_9) ^ gf_mul(t[k * 4 + 3], MIX_E);
                    end
                end
            end
            for (int i = 0; i < 16; i++)
                packed_st[127 - 8 * i -: 8] = st[i];
            return packed_st;
        endfunction

        // Note an accepted ciphertext request and queue the plaintext it must produce.
        function void take_cipher(logic [63:0] hi, logic [63:0] lo, logic start);
            logic [31:0]  w [4 * (ROUNDS + 1)];
            logic [31:0]  t;
            logic [7:0]   rc;
            logic [127:0] plain_blk;
            if (keys_stale) begin
                w[0] = key_high[63:32];
                w[1] = key_high[31:0];
                w[2] = key_low[63:32];
                w[3] = key_low[31:0];
                rc = RCON_FIRST;
                for (int i = 4; i < 4 * (ROUNDS + 1); i++) begin
                    t = w[i - 1];
                    if (i % 4 == 0) begin
                        t = {t[23:0], t[31:24]};
                        t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]],
                             fwd_box[t[7:0]]} ^ {rc, 24'h000000};
                        rc = gf_mul(rc, RCON_STEP);
                    end
                    w[i] = w[i - 4] ^ t;
                end
                for (int r = 0; r <= ROUNDS; r++)
                    round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
                keys_stale = 1'b0;
            end
            plain_blk = invert_block({hi, lo});
            if (!start)
                plain_blk ^= {chain_high, chain_low};
            chain_high = hi;
            chain_low  = lo;
            plain_due = {plain_due, plain_blk};
        endfunction

        function void match_plain(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] want;
            if (plain_due.size() == 0) begin
                $error("plain: block %h_%h with no request outstanding", hi, lo);
                errors++;
                return;
            end
            want = plain_due.pop_front();
            if (want[127:64] !== hi) begin
                $error("plain_high: expected %h, actual %h", want[127:64], hi);
                errors++;
            end
            if (want[63:0] !== lo) begin
                $error("plain_low: expected %h, actual %h", want[63:0], lo);
                errors++;
            end
        endfunction

        function int pending();
            return plain_due.size();
        endfunction
    endclass

endpackage

[test/tb_aes128_cbc_decrypt.sv]
`timescale 1ns / 100ps
// Top-level testbench for aes128_cbc_decrypt: drives ciphertext and key writes, checks plaintext.
// Depends on aescbc_pkg, the aescbc_*_if interfaces and cbc_check_pkg.
module tb_aes128_cbc_decrypt;

    import aescbc_pkg::*;
    import cbc_check_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int RANDOM_BLOCKS   = 800;
    localparam int SEGMENTS        = 4;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic [CFG_IDX_W-1:0] UNMAPPED_INDEX = '1;

    typedef enum int {
        PH_RECV_SLOW,
        PH_SEND_SLOW,
        PH_FULL_RATE
    } pace_t;

    logic  clk;
    logic  rst_n;
    pace_t pace = PH_RECV_SLOW;
    int    send_idle_pct = 10;
    int    recv_idle_pct = 77;
    bit    hold_off = 1'b0;

    cbc_plain_check board;

    aescbc_in_if  cipher ();
    aescbc_out_if plain ();
    aescbc_cfg_if cfg ();

    aes128_cbc_decrypt u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cipher (cipher),
        .plain  (plain),
        .cfg    (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("aes128_cbc_decrypt verification failed");
        $finish;
    end

    initial
    begin
        plain.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            plain.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver stall at full rate so the block backs up onto its input.
    initial
    begin
        wait (pace == PH_FULL_RATE);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && plain.valid && plain.ready)
            board.match_plain(plain.plain_high, plain.plain_low);
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cipher.valid <= 1'b0;
            @(negedge clk);
        end
        cipher.valid       <= 1'b1;
        cipher.cipher_high <= hi;
        cipher.cipher_low  <= lo;
        cipher.chain_start <= start;
        @(posedge clk);
        while (!cipher.ready) @(posedge clk);
        board.take_cipher(hi, lo, start);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        board.write_key(index, value);
        @(negedge clk);
    endtask

    // Drop the request line and wait until every plaintext is back and the block is quiet.
    task automatic settle();
        cipher.valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic rekey();
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(255, int'(REG_KEY_LOW) + 1));
        settle();
        case ($urandom_range(5))
            0:
            begin
                write_reg(REG_KEY_HIGH, rand_word());
                write_reg(REG_KEY_LOW, rand_word());
            end
            1:
            begin
                write_reg(REG_KEY_HIGH, '0);
                write_reg(REG_KEY_LOW, '0);
            end
            2:
            begin
                write_reg(REG_KEY_LOW, '1);
                write_reg(REG_KEY_HIGH, '1);
            end
            3: write_reg(REG_KEY_HIGH, {$urandom, $urandom});
            4: write_reg(REG_KEY_LOW, {$urandom, $urandom});
            default:
            begin
                write_reg(spare, {$urandom, $urandom});
                write_reg(REG_KEY_HIGH, {$urandom, $urandom});
                write_reg(REG_KEY_LOW, {$urandom, $urandom});
            end
        endcase
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        rst_n              = 1'b0;
        cipher.valid       = 1'b0;
        cipher.cipher_high = '0;
        cipher.cipher_low  = '0;
        cipher.chain_start = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_KEY_HIGH;
        cfg.data           = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no key written yet: all-zero key, chaining value from reset
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);

        // known CBC chain, then keep chaining across key changes
        settle();
        write_reg(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_reg(REG_KEY_LOW, 64'habf7158809cf4f3c);
        cfg.valid <= 1'b0;
        send_block(64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b1);
        send_block(64'h5086cb9b507219ee, 64'h95db113a917678b2, 1'b0);

        // half of the key replaced
        settle();
        write_reg(REG_KEY_HIGH, '1);
        cfg.valid <= 1'b0;
        send_block('1, '0, 1'b0);
        send_block('0, '1, 1'b1);

        // write to an unmapped index must leave the key alone
        settle();
        write_reg(REG_KEY_LOW, '1);
        write_reg(UNMAPPED_INDEX, 64'h0f0f0f0f0f0f0f0f);
        cfg.valid <= 1'b0;
        send_block(64'h8000000000000001, 64'h0000000000000001, 1'b0);
        send_block(64'h7fffffffffffffff, 64'hfffffffffffffffe, 1'b0);

        settle();
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_KEY_LOW, '0);
        write_reg(UNMAPPED_INDEX, '1);
        cfg.valid <= 1'b0;
        send_block(64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1);
        send_block(64'hffffffff00000000, 64'h00000000ffffffff, 1'b0);

        for (int p = 0; p < 3; p++)
        begin
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                rekey();
                if (seg == 0)
                begin
                    send_idle_pct = (p == PH_SEND_SLOW) ? 77 : (p == PH_RECV_SLOW) ? 10 : 0;
                    recv_idle_pct = (p == PH_RECV_SLOW) ? 77 : (p == PH_SEND_SLOW) ? 10 : 0;
                    pace = pace_t'(p);
                end
                for (int n = 0; n < RANDOM_BLOCKS / (3 * SEGMENTS); n++)
                    send_block(rand_word(), rand_word(), $urandom_range(7) == 0);
            end
        end

        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("aes128_cbc_decrypt verification clean");
        else
            $display("aes128_cbc_decrypt verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/aescbc_pkg.sv
hw/rtl/aescbc_intf.sv
hw/rtl/aescbc_key_expand.sv
hw/rtl/aescbc_round.sv
hw/rtl/aes128_cbc_decrypt.sv
test/cbc_check_pkg.sv
test/tb_aes128_cbc_decrypt.sv
